@@ src/bpd_pkg.sv @@
// Shared types, codes and constants of the B-Plus packet deframer.
package bpd_pkg;

    localparam int unsigned COUNT_W = 12;
    localparam logic [COUNT_W-1:0] MAX_BODY = 12'd2066;

    localparam logic [7:0] CHR_ETX   = 8'h03;
    localparam logic [7:0] CHR_ENQ   = 8'h05;
    localparam logic [7:0] CHR_DLE   = 8'h10;
    localparam logic [7:0] CHR_NAK   = 8'h15;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_B     = 8'h42;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        FR_GET_DLE   = 2'd0,
        FR_DLE_SEEN  = 2'd1,
        FR_GET_DATA  = 2'd2,
        FR_GET_CHECK = 2'd3
    } t_frame;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_DATA     = 4'd1,
        EV_STRAY    = 4'd2,
        EV_ENQ_ACK  = 4'd3,
        EV_IDLE_ENQ = 4'd4,
        EV_NAK      = 4'd5,
        EV_ACK_RX   = 4'd6,
        EV_GOOD     = 4'd7,
        EV_BAD_CHK  = 4'd8,
        EV_BAD_SEQ  = 4'd9
    } t_event;

    typedef struct packed {
        t_frame               frame_state;
        logic                 quote_pending;
        logic [COUNT_W-1:0]   body_count;
        logic [7:0]           seq_byte;
        logic [7:0]           type_byte;
        logic [15:0]          check_calc;
        logic [15:0]          check_recv;
        logic [1:0]           check_left;
        logic [3:0]           packet_number;
    } t_state;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] data_byte;
        logic [3:0] digit;
        logic       ack_needed;
    } t_result;

endpackage

@@ src/bpd_check.sv @@
// Running check update for one byte: end-around-carry checksum or CRC-16.
module bpd_check (
    input  logic        i_mode,
    input  logic [15:0] i_calc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_calc
);

    logic [15:0] sum_shift;
    logic [8:0]  sum_fold;
    logic [8:0]  sum_add;
    logic [7:0]  sum_res;
    logic [15:0] crc;

    always_comb begin
        // Checksum: rotate-like shift with end-around carry, then add with carry.
        sum_shift = {i_calc[14:0], 1'b0};
        if (sum_shift[15:8] != 8'd0) begin
            sum_fold = {1'b0, sum_shift[7:0]} + 9'd1;
        end else begin
            sum_fold = {1'b0, sum_shift[7:0]};
        end
        sum_add = sum_fold + {1'b0, i_byte};
        if (sum_add[8]) begin
            sum_res = sum_add[7:0] + 8'd1;
        end else begin
            sum_res = sum_add[7:0];
        end

        // CRC-16, MSB first, one bit per step over the byte.
        crc = i_calc ^ {i_byte, 8'd0};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ bpd_pkg::CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end

        o_calc = i_mode ? crc : {8'd0, sum_res};
    end

endmodule

@@ src/bpd_step.sv @@
// Next-state and result logic of the deframer for one received byte.
module bpd_step (
    input  logic              i_check_mode,
    input  logic [7:0]        i_byte,
    input  bpd_pkg::t_state   i_state,
    output bpd_pkg::t_state   o_state,
    output bpd_pkg::t_result  o_result
);

    logic [7:0]  byte_dq;
    logic [7:0]  fold_in;
    logic [15:0] fold_out;
    logic [15:0] recv_next;
    logic [1:0]  left_next;
    logic [3:0]  pnum_next;
    logic [7:0]  seq_expect;

    function automatic logic [7:0] unquote(input logic [7:0] b);
        logic [7:0] r;
        if (b[7:5] == 3'b010) begin
            r = b - 8'h40;
        end else if (b[7:5] == 3'b011) begin
            r = b + 8'h20;
        end else begin
            r = b;
        end
        return r;
    endfunction

    assign byte_dq = i_state.quote_pending ? unquote(i_byte) : i_byte;
    // The ETX closing the body enters the check raw.
    assign fold_in = (i_byte == bpd_pkg::CHR_ETX) ? i_byte : byte_dq;

    bpd_check u_check (
        .i_mode (i_check_mode),
        .i_calc (i_state.check_calc),
        .i_byte (fold_in),
        .o_calc (fold_out)
    );

    assign recv_next  = {i_state.check_recv[7:0], byte_dq};
    assign left_next  = (i_state.check_left != 2'd0) ? i_state.check_left - 2'd1 : 2'd0;
    assign pnum_next  = (i_state.packet_number == 4'd9) ? 4'd0 : i_state.packet_number + 4'd1;
    assign seq_expect = {4'd0, pnum_next} + bpd_pkg::CHR_ZERO;

    always_comb begin
        o_state  = i_state;
        o_result = '{event_res: bpd_pkg::EV_NONE, data_byte: 8'd0, digit: 4'd0,
                     ack_needed: 1'b0};

        unique case (i_state.frame_state)
            bpd_pkg::FR_GET_DLE: begin
                if (i_byte == bpd_pkg::CHR_ETX) begin
                    o_result.event_res = bpd_pkg::EV_STRAY;
                end else if (i_byte == bpd_pkg::CHR_ENQ) begin
                    o_result.event_res = bpd_pkg::EV_IDLE_ENQ;
                    o_result.digit     = i_state.packet_number;
                end else if (i_byte == bpd_pkg::CHR_DLE) begin
                    o_state.frame_state = bpd_pkg::FR_DLE_SEEN;
                end else if (i_byte == bpd_pkg::CHR_NAK) begin
                    o_result.event_res = bpd_pkg::EV_NAK;
                end
            end
            bpd_pkg::FR_DLE_SEEN: begin
                if (i_byte == bpd_pkg::CHR_ENQ) begin
                    o_result.event_res  = bpd_pkg::EV_ENQ_ACK;
                    o_result.digit      = i_state.packet_number;
                    o_state.frame_state = bpd_pkg::FR_GET_DLE;
                end else if (i_byte == bpd_pkg::CHR_SEMI) begin
                    o_state.frame_state = bpd_pkg::FR_GET_DLE;
                end else if (i_byte == bpd_pkg::CHR_B) begin
                    o_state.body_count    = '0;
                    o_state.quote_pending = 1'b0;
                    o_state.frame_state   = bpd_pkg::FR_GET_DATA;
                    if (i_check_mode) begin
                        o_state.check_calc = bpd_pkg::CRC_SEED;
                        o_state.check_left = 2'd2;
                    end else begin
                        o_state.check_calc = 16'd0;
                        o_state.check_left = 2'd1;
                    end
                end else if (i_byte >= bpd_pkg::CHR_ZERO && i_byte <= bpd_pkg::CHR_NINE) begin
                    o_result.event_res  = bpd_pkg::EV_ACK_RX;
                    o_result.digit      = i_byte[3:0];
                    o_state.frame_state = bpd_pkg::FR_GET_DLE;
                end
            end
            bpd_pkg::FR_GET_DATA: begin
                if (i_byte == bpd_pkg::CHR_ETX) begin
                    o_state.check_calc    = fold_out;
                    o_state.quote_pending = 1'b0;
                    o_state.check_recv    = 16'd0;
                    o_state.frame_state   = bpd_pkg::FR_GET_CHECK;
                end else if (i_byte == bpd_pkg::CHR_ENQ) begin
                    o_result.event_res  = bpd_pkg::EV_ENQ_ACK;
                    o_result.digit      = i_state.packet_number;
                    o_state.frame_state = bpd_pkg::FR_GET_DLE;
                end else if (i_byte == bpd_pkg::CHR_DLE) begin
                    o_state.quote_pending = 1'b1;
                end else begin
                    o_state.quote_pending = 1'b0;
                    if (i_state.body_count < bpd_pkg::MAX_BODY) begin
                        o_state.check_calc = fold_out;
                        if (i_state.body_count == '0) begin
                            o_state.seq_byte = byte_dq;
                        end else if (i_state.body_count == 12'd1) begin
                            o_state.type_byte = byte_dq;
                        end
                        o_state.body_count = i_state.body_count + 12'd1;
                        o_result.event_res = bpd_pkg::EV_DATA;
                        o_result.data_byte = byte_dq;
                    end
                end
            end
            bpd_pkg::FR_GET_CHECK: begin
                if (i_byte == bpd_pkg::CHR_DLE) begin
                    o_state.quote_pending = 1'b1;
                end else begin
                    o_state.quote_pending = 1'b0;
                    o_state.check_recv    = recv_next;
                    o_state.check_left    = left_next;
                    if (left_next == 2'd0) begin
                        o_state.frame_state = bpd_pkg::FR_GET_DLE;
                        if (recv_next != i_state.check_calc) begin
                            o_result.event_res = bpd_pkg::EV_BAD_CHK;
                        end else if (seq_expect != i_state.seq_byte) begin
                            o_result.event_res = bpd_pkg::EV_BAD_SEQ;
                        end else begin
                            o_state.packet_number = pnum_next;
                            o_result.event_res    = bpd_pkg::EV_GOOD;
                            o_result.data_byte    = i_state.type_byte;
                            o_result.digit        = pnum_next;
                            o_result.ack_needed   = (i_state.type_byte != bpd_pkg::CHR_PLUS);
                        end
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

@@ src/bplus_packet_deframer_core.sv @@
// Top level of the B-Plus packet deframer: handshakes, registers and checks.
//
// The deframer takes one raw link byte per request on the slave stream and
// gives exactly one result per byte on the master stream, in order. A byte
// is first captured in an input register; once the result register is free,
// the frame state, the running check and the result are computed from it
// and the result is registered. Throughput is one byte per clock whenever
// the master side keeps taking results; a stalled result holds the byte
// behind it in the input register, and the slave side stalls only while
// both registers are full. The longest path is the unrolled eight-step
// CRC-16 byte update feeding the check register. Bytes outside a packet
// report control events (stray ETX, ENQ, NAK, DLE-digit acknowledge, DLE
// ENQ); DLE B opens a packet, whose dequoted body bytes are streamed out
// as data events. After ETX and the one or two check bytes, a good,
// bad-check or bad-sequence event closes the packet. The check_mode
// register selects the 8-bit end-around-carry checksum (0) or CRC-16 (1);
// write it only while no byte is in flight. The number of check bytes is
// fixed when a packet opens.
module bplus_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,     // [0] check_mode
    // Received byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] digit,
                                        // [12] ack_needed, [15:13] zero
    output logic [3:0]  m_axis_tuser    // [3:0] event_res
);

    logic              r_check_mode;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    bpd_pkg::t_state   r_state;
    logic              r_out_valid;
    bpd_pkg::t_result  r_out;

    logic              n_in_valid;
    logic              n_out_valid;
    bpd_pkg::t_state   n_state;
    bpd_pkg::t_result  n_out;

    logic              out_free;
    logic              advance;
    logic              in_take;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || m_axis_tready;
    // The captured byte is processed once its result has somewhere to go.
    assign advance  = r_in_valid && out_free;
    // The input register accepts a new byte when empty or emptying now.
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready = 1'b1;

    bpd_step u_step (
        .i_check_mode (r_check_mode),
        .i_byte       (r_in_byte),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_out)
    );

    assign n_in_valid  = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = advance ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= '{frame_state: bpd_pkg::FR_GET_DLE, default: '0};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_check_mode <= i_cfg_data;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.ack_needed, r_out.digit, r_out.data_byte};
    assign m_axis_tuser  = r_out.event_res;

    // The packet number counts modulo ten.
    a_pnum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.packet_number <= 4'd9)
        else $error("packet number left the range 0 to 9");

    // While check bytes are expected, at least one is still outstanding.
    a_check_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.frame_state == bpd_pkg::FR_GET_CHECK |-> r_state.check_left != 2'd0)
        else $error("check byte count exhausted inside the check phase");

    // Only data and good-packet results carry a byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res != bpd_pkg::EV_DATA
         && r_out.event_res != bpd_pkg::EV_GOOD) |-> r_out.data_byte == 8'd0)
        else $error("data byte set on a control result");

    // A good packet asks for an acknowledge exactly when its type is not '+'.
    a_ack_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == bpd_pkg::EV_GOOD)
        |-> r_out.ack_needed == (r_out.data_byte != bpd_pkg::CHR_PLUS))
        else $error("acknowledge request disagrees with packet type");

    // Each processed byte yields a result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed byte produced no result");

endmodule
